FILE: hdl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared widths, codes and structs of the clipped rectangle rasterizer.
// ----------------------------------------------------------------------------
package crr_pkg;

  localparam int COORD_W = 13;  // width of the signed corner coordinates
  localparam int FRAME_W = 12;  // width of frame limits and pixel positions
  localparam int COL_W   = 8;   // width of one colour component
  // Internal signed width: holds both a corner and a frame limit.
  localparam int CMP_W   = ((COORD_W > FRAME_W) ? COORD_W : FRAME_W) + 1;
  localparam int IDX_W   = 2;   // width of the register index

  localparam logic [1:0] FUNC_OUTLINE = 2'd0;
  localparam logic [1:0] FUNC_FILL    = 2'd1;
  localparam logic [1:0] FUNC_STEP    = 2'd2;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_OUTLINE = 2'd1;
  localparam logic [1:0] MODE_FILL    = 2'd2;

  localparam logic PHASE_COLS = 1'b0;
  localparam logic PHASE_ROWS = 1'b1;

  localparam logic [IDX_W-1:0] CFG_FRAME_MAX_X = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FRAME_MAX_Y = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_MAX_X_RST = 12'd639;
  localparam logic [FRAME_W-1:0] FRAME_MAX_Y_RST = 12'd479;

  typedef logic signed [CMP_W-1:0] ext_t;

  // Clamped bounds and start decision for one start command.
  typedef struct packed {
    ext_t       l;
    ext_t       t;
    ext_t       e;
    ext_t       d;
    logic [3:0] edges;   // bit0 left, bit1 right, bit2 top, bit3 bottom
    logic [1:0] mode;
    logic       phase;
  } clip_t;

  typedef struct packed {
    logic               write_valid;
    logic [FRAME_W-1:0] pixel_x;
    logic [FRAME_W-1:0] pixel_y;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
    logic               last_write;
    logic               busy;
  } result_t;

endpackage

FILE: hdl/crr_clip.sv
// ----------------------------------------------------------------------------
// crr_clip
// Clamps the rectangle corners to the frame and picks the starting mode.
// ----------------------------------------------------------------------------
module crr_clip (
  input  logic [1:0]                   func,
  input  logic [crr_pkg::COORD_W-1:0]  rect_left,
  input  logic [crr_pkg::COORD_W-1:0]  rect_top,
  input  logic [crr_pkg::COORD_W-1:0]  rect_right,
  input  logic [crr_pkg::COORD_W-1:0]  rect_bottom,
  input  logic [crr_pkg::FRAME_W-1:0]  frame_max_x,
  input  logic [crr_pkg::FRAME_W-1:0]  frame_max_y,
  output crr_pkg::clip_t               clip
);
  import crr_pkg::*;

  ext_t left_x, top_x, right_x, bottom_x, max_x, max_y;
  ext_t l, t, e, d;
  logic [3:0] edges;

  assign left_x   = ext_t'({{(CMP_W-COORD_W){rect_left[COORD_W-1]}}, rect_left});
  assign top_x    = ext_t'({{(CMP_W-COORD_W){rect_top[COORD_W-1]}}, rect_top});
  assign right_x  = ext_t'({{(CMP_W-COORD_W){rect_right[COORD_W-1]}}, rect_right});
  assign bottom_x = ext_t'({{(CMP_W-COORD_W){rect_bottom[COORD_W-1]}}, rect_bottom});
  assign max_x    = ext_t'({{(CMP_W-FRAME_W){1'b0}}, frame_max_x});
  assign max_y    = ext_t'({{(CMP_W-FRAME_W){1'b0}}, frame_max_y});

  assign edges[0] = ~left_x[CMP_W-1];
  assign edges[1] = (right_x <= max_x);
  assign edges[2] = ~top_x[CMP_W-1];
  assign edges[3] = (bottom_x <= max_y);

  assign l = edges[0] ? left_x  : '0;
  assign t = edges[2] ? top_x   : '0;
  assign e = edges[1] ? right_x : max_x;
  assign d = edges[3] ? bottom_x : max_y;

  always_comb begin
    clip.l     = l;
    clip.t     = t;
    clip.e     = e;
    clip.d     = d;
    clip.edges = edges;
    clip.mode  = MODE_IDLE;
    clip.phase = PHASE_COLS;
    if ((l <= e) && (t <= d)) begin
      priority if (func == FUNC_FILL) begin
        clip.mode = MODE_FILL;
      end else if (edges[1:0] != 2'b00) begin
        clip.mode = MODE_OUTLINE;
      end else if (edges[3:2] != 2'b00) begin
        // no side columns: go straight to the top and bottom rows
        clip.mode  = MODE_OUTLINE;
        clip.phase = PHASE_ROWS;
      end else begin
        // every edge off frame: draw nothing
        clip.mode = MODE_IDLE;
      end
    end
  end

endmodule

FILE: hdl/crr_engine.sv
// ----------------------------------------------------------------------------
// crr_engine
// Drawing state and cursor; produces one result for each word it takes.
// ----------------------------------------------------------------------------
module crr_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [1:0]                   func,
  input  crr_pkg::clip_t               clip,
  input  logic [crr_pkg::COL_W-1:0]    red_in,
  input  logic [crr_pkg::COL_W-1:0]    green_in,
  input  logic [crr_pkg::COL_W-1:0]    blue_in,
  output crr_pkg::result_t             res
);
  import crr_pkg::*;

  logic [1:0]       mode_r, mode_nxt;
  logic             phase_r, phase_nxt;
  logic             tog_r, tog_nxt;
  logic [3:0]       edges_r, edges_nxt;
  ext_t             cx_r, cx_nxt, cy_r, cy_nxt;
  ext_t             l_r, l_nxt, t_r, t_nxt, e_r, e_nxt, d_r, d_nxt;
  logic [COL_W-1:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  ext_t             px, py;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    tog_nxt   = tog_r;
    edges_nxt = edges_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    l_nxt     = l_r;
    t_nxt     = t_r;
    e_nxt     = e_r;
    d_nxt     = d_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    px        = cx_r;
    py        = cy_r;
    res       = '0;
    res.busy  = (mode_r != MODE_IDLE);

    if (fire) begin
      unique case (func)
        FUNC_OUTLINE, FUNC_FILL: begin
          l_nxt     = clip.l;
          t_nxt     = clip.t;
          e_nxt     = clip.e;
          d_nxt     = clip.d;
          edges_nxt = clip.edges;
          mode_nxt  = clip.mode;
          phase_nxt = clip.phase;
          tog_nxt   = 1'b0;
          cx_nxt    = clip.l;
          cy_nxt    = clip.t;
          red_nxt   = red_in;
          green_nxt = green_in;
          blue_nxt  = blue_in;
          res.busy  = (clip.mode != MODE_IDLE);
        end
        FUNC_STEP: begin
          if (mode_r != MODE_IDLE) begin
            if (mode_r == MODE_OUTLINE) begin
              if (phase_r == PHASE_COLS) begin
                px = (tog_r || !edges_r[0]) ? e_r : l_r;
              end else begin
                py = (tog_r || !edges_r[2]) ? d_r : t_r;
              end
            end

            // advance the cursor to the next write
            if (mode_r == MODE_FILL) begin
              priority if (cx_r != e_r) begin
                cx_nxt = cx_r + 1'b1;
              end else if (cy_r != d_r) begin
                cx_nxt = l_r;
                cy_nxt = cy_r + 1'b1;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end else if (phase_r == PHASE_COLS) begin
              priority if (!tog_r && (edges_r[1:0] == 2'b11)) begin
                tog_nxt = 1'b1;
              end else if (cy_r != d_r) begin
                tog_nxt = 1'b0;
                cy_nxt  = cy_r + 1'b1;
              end else if (edges_r[3:2] != 2'b00) begin
                tog_nxt   = 1'b0;
                phase_nxt = PHASE_ROWS;
                cx_nxt    = l_r;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end else begin
              priority if (!tog_r && (edges_r[3:2] == 2'b11)) begin
                tog_nxt = 1'b1;
              end else if (cx_r != e_r) begin
                tog_nxt = 1'b0;
                cx_nxt  = cx_r + 1'b1;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end

            res.write_valid = 1'b1;
            res.pixel_x     = px[FRAME_W-1:0];
            res.pixel_y     = py[FRAME_W-1:0];
            res.red         = red_r;
            res.green       = green_r;
            res.blue        = blue_r;
            res.last_write  = (mode_nxt == MODE_IDLE);
            res.busy        = (mode_nxt != MODE_IDLE);
          end
        end
        default: begin
          // unused code: hold everything
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= PHASE_COLS;
      tog_r   <= 1'b0;
      edges_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      tog_r   <= tog_nxt;
      edges_r <= edges_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    l_r     <= l_nxt;
    t_r     <= t_nxt;
    e_r     <= e_nxt;
    d_r     <= d_nxt;
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

endmodule

FILE: hdl/clipped_rectangle_rasterizer.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_rasterizer
// Outline or filled rectangle, clipped to the frame, one pixel write per step.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall   func, corners, colour
//   out_      output     out_valid / out_stall pixel write and status
//   cfg_      input      cfg_valid / cfg_ready frame limits by index
//
// One word in per cycle unless in_stall, one result per word; each word
// fills the input register, then clip and cursor feed the result register.
// A full result register that is stalled holds the input register, and
// in_stall rises only while both are occupied. cfg_ready is always high.
// Synchronous active-low reset: idle, frame limits 639 x 479.
module clipped_rectangle_rasterizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [crr_pkg::COORD_W-1:0]   in_rect_left,
  input  logic [crr_pkg::COORD_W-1:0]   in_rect_top,
  input  logic [crr_pkg::COORD_W-1:0]   in_rect_right,
  input  logic [crr_pkg::COORD_W-1:0]   in_rect_bottom,
  input  logic [crr_pkg::COL_W-1:0]     in_red_in,
  input  logic [crr_pkg::COL_W-1:0]     in_green_in,
  input  logic [crr_pkg::COL_W-1:0]     in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_valid,
  output logic [crr_pkg::FRAME_W-1:0]   out_pixel_x,
  output logic [crr_pkg::FRAME_W-1:0]   out_pixel_y,
  output logic [crr_pkg::COL_W-1:0]     out_red_out,
  output logic [crr_pkg::COL_W-1:0]     out_green_out,
  output logic [crr_pkg::COL_W-1:0]     out_blue_out,
  output logic                          out_last_write,
  output logic                          out_busy_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [crr_pkg::IDX_W-1:0]     cfg_index,
  input  logic [crr_pkg::FRAME_W-1:0]   cfg_data
);
  import crr_pkg::*;

  logic [FRAME_W-1:0] max_x_r, max_y_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic [1:0]         s1_func_r;
  logic [COORD_W-1:0] s1_left_r, s1_top_r, s1_right_r, s1_bottom_r;
  logic [COL_W-1:0]   s1_red_r, s1_green_r, s1_blue_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            res, res_r;
  clip_t              clip;
  logic               adv, accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r <= FRAME_MAX_X_RST;
      max_y_r <= FRAME_MAX_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAME_MAX_X) max_x_r <= cfg_data;
      if (cfg_index == CFG_FRAME_MAX_Y) max_y_r <= cfg_data;
    end
  end

  // advance the held word into the result register when it has room
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)   s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (adv)             out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r   <= in_func;
      s1_left_r   <= in_rect_left;
      s1_top_r    <= in_rect_top;
      s1_right_r  <= in_rect_right;
      s1_bottom_r <= in_rect_bottom;
      s1_red_r    <= in_red_in;
      s1_green_r  <= in_green_in;
      s1_blue_r   <= in_blue_in;
    end
    if (adv) res_r <= res;
  end

  crr_clip u_clip (
    .func        (s1_func_r),
    .rect_left   (s1_left_r),
    .rect_top    (s1_top_r),
    .rect_right  (s1_right_r),
    .rect_bottom (s1_bottom_r),
    .frame_max_x (max_x_r),
    .frame_max_y (max_y_r),
    .clip        (clip)
  );

  crr_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .func     (s1_func_r),
    .clip     (clip),
    .red_in   (s1_red_r),
    .green_in (s1_green_r),
    .blue_in  (s1_blue_r),
    .res      (res)
  );

  assign out_valid       = out_valid_r;
  assign out_write_valid = res_r.write_valid;
  assign out_pixel_x     = res_r.pixel_x;
  assign out_pixel_y     = res_r.pixel_y;
  assign out_red_out     = res_r.red;
  assign out_green_out   = res_r.green;
  assign out_blue_out    = res_r.blue;
  assign out_last_write  = res_r.last_write;
  assign out_busy_res    = res_r.busy;

endmodule

FILE: tb/tb_clipped_rectangle_rasterizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_rectangle_rasterizer
// Drives start, step and unused words into the rasterizer and checks every
// result word against an in-bench model of the clip and cursor logic, over
// several frame sizes, idling mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_clipped_rectangle_rasterizer;
  import crr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam int         DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
  } rect_word_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func        = FUNC_STEP;
  logic [COORD_W-1:0] in_rect_left   = '0;
  logic [COORD_W-1:0] in_rect_top    = '0;
  logic [COORD_W-1:0] in_rect_right  = '0;
  logic [COORD_W-1:0] in_rect_bottom = '0;
  logic [COL_W-1:0]   in_red_in      = '0;
  logic [COL_W-1:0]   in_green_in    = '0;
  logic [COL_W-1:0]   in_blue_in     = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_write_valid;
  logic [FRAME_W-1:0] out_pixel_x;
  logic [FRAME_W-1:0] out_pixel_y;
  logic [COL_W-1:0]   out_red_out;
  logic [COL_W-1:0]   out_green_out;
  logic [COL_W-1:0]   out_blue_out;
  logic               out_last_write;
  logic               out_busy_res;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index      = CFG_FRAME_MAX_X;
  logic [FRAME_W-1:0] cfg_data       = '0;

  // model of the block
  logic [FRAME_W-1:0] frame_lim_x = FRAME_MAX_X_RST;
  logic [FRAME_W-1:0] frame_lim_y = FRAME_MAX_Y_RST;
  logic [1:0]         pen_mode    = MODE_IDLE;
  logic               pen_phase   = PHASE_COLS;
  logic               pen_pair    = 1'b0;
  ext_t               pen_x       = '0;
  ext_t               pen_y       = '0;
  ext_t               box_l       = '0;
  ext_t               box_t       = '0;
  ext_t               box_r       = '0;
  ext_t               box_b       = '0;
  logic [3:0]         box_edges   = '0;
  logic [23:0]        pen_colour  = '0;

  result_t pixel_results_due[$];
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      hold_left     = 0;
  int      errors        = 0;
  int      words_sent    = 0;
  int      results_seen  = 0;
  int      writes_seen   = 0;

  clipped_rectangle_rasterizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_rect_left    (in_rect_left),
    .in_rect_top     (in_rect_top),
    .in_rect_right   (in_rect_right),
    .in_rect_bottom  (in_rect_bottom),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_write_valid (out_write_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .out_last_write  (out_last_write),
    .out_busy_res    (out_busy_res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one accepted word and move the model on.
  function automatic result_t rasterize_word(input rect_word_t w);
    result_t res;
    ext_t    lf, tp, rt, bt, mx, my, px, py;
    res = '0;
    if (w.func == FUNC_OUTLINE || w.func == FUNC_FILL) begin
      lf = {w.left[COORD_W-1], w.left};
      tp = {w.top[COORD_W-1], w.top};
      rt = {w.right[COORD_W-1], w.right};
      bt = {w.bottom[COORD_W-1], w.bottom};
      mx = {2'b00, frame_lim_x};
      my = {2'b00, frame_lim_y};
      box_l      = (lf < 0) ? '0 : lf;
      box_t      = (tp < 0) ? '0 : tp;
      box_r      = (rt > mx) ? mx : rt;
      box_b      = (bt > my) ? my : bt;
      box_edges  = {bt <= my, tp >= 0, rt <= mx, lf >= 0};
      pen_colour = {w.red, w.green, w.blue};
      pen_pair   = 1'b0;
      pen_phase  = PHASE_COLS;
      pen_x      = box_l;
      pen_y      = box_t;
      pen_mode   = MODE_IDLE;
      if (box_l <= box_r && box_t <= box_b) begin
        if (w.func == FUNC_FILL) begin
          pen_mode = MODE_FILL;
        end else if (box_edges[1:0] != 2'b00) begin
          pen_mode = MODE_OUTLINE;
        end else if (box_edges[3:2] != 2'b00) begin
          pen_mode  = MODE_OUTLINE;
          pen_phase = PHASE_ROWS;
        end
      end
    end else if (w.func == FUNC_STEP && pen_mode != MODE_IDLE) begin
      px = pen_x;
      py = pen_y;
      if (pen_mode == MODE_OUTLINE) begin
        if (pen_phase == PHASE_COLS)
          px = (pen_pair || !box_edges[0]) ? box_r : box_l;
        else
          py = (pen_pair || !box_edges[2]) ? box_b : box_t;
      end
      res.write_valid = 1'b1;
      res.pixel_x     = px[FRAME_W-1:0];
      res.pixel_y     = py[FRAME_W-1:0];
      {res.red, res.green, res.blue} = pen_colour;
      // advance the cursor: columns pair left/right per row, rows pair top/bottom
      if (pen_mode == MODE_FILL) begin
        if (pen_x != box_r) begin
          pen_x = pen_x + 1'b1;
        end else if (pen_y != box_b) begin
          pen_x = box_l;
          pen_y = pen_y + 1'b1;
        end else begin
          pen_mode = MODE_IDLE;
        end
      end else if (pen_phase == PHASE_COLS) begin
        if (!pen_pair && box_edges[1:0] == 2'b11) begin
          pen_pair = 1'b1;
        end else if (pen_y != box_b) begin
          pen_pair = 1'b0;
          pen_y    = pen_y + 1'b1;
        end else if (box_edges[3:2] != 2'b00) begin
          pen_pair  = 1'b0;
          pen_phase = PHASE_ROWS;
          pen_x     = box_l;
        end else begin
          pen_mode = MODE_IDLE;
        end
      end else begin
        if (!pen_pair && box_edges[3:2] == 2'b11) begin
          pen_pair = 1'b1;
        end else if (pen_x != box_r) begin
          pen_pair = 1'b0;
          pen_x    = pen_x + 1'b1;
        end else begin
          pen_mode = MODE_IDLE;
        end
      end
      res.last_write = (pen_mode == MODE_IDLE);
    end
    res.busy = (pen_mode != MODE_IDLE);
    return res;
  endfunction

  function automatic int fit_coord(input int v);
    if (v < -4096) return -4096;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // Pick a corner near the origin, near the frame limit, or anywhere inside.
  function automatic int near_edge(input int lim);
    case ($urandom_range(0, 2))
      0:       return fit_coord(int'($urandom_range(0, 6)) - 3);
      1:       return fit_coord(lim + int'($urandom_range(0, 6)) - 3);
      default: return int'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic rect_word_t make_word(input logic [1:0] func, input int lf, input int tp,
                                           input int rt, input int bt,
                                           input logic [23:0] colour);
    rect_word_t w;
    w.func   = func;
    w.left   = lf[COORD_W-1:0];
    w.top    = tp[COORD_W-1:0];
    w.right  = rt[COORD_W-1:0];
    w.bottom = bt[COORD_W-1:0];
    {w.red, w.green, w.blue} = colour;
    return w;
  endfunction

  function automatic rect_word_t step_word();
    return make_word(FUNC_STEP, int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom), 24'($urandom));
  endfunction

  task automatic send_word(input rect_word_t w);
    int gap;
    in_valid       <= 1'b1;
    in_func        <= w.func;
    in_rect_left   <= w.left;
    in_rect_top    <= w.top;
    in_rect_right  <= w.right;
    in_rect_bottom <= w.bottom;
    in_red_in      <= w.red;
    in_green_in    <= w.green;
    in_blue_in     <= w.blue;
    do @(posedge clk); while (in_stall);
    pixel_results_due.push_back(rasterize_word(w));
    words_sent++;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    // keep valid high when the next word follows at once
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Start a rectangle, then step until it is done or the step budget runs out.
  task automatic draw_rect(input logic [1:0] func, input int lf, input int tp, input int rt,
                           input int bt, input logic [23:0] colour, input int max_steps,
                           input int extra_steps);
    int n;
    send_word(make_word(func, lf, tp, rt, bt, colour));
    n = 0;
    while (pen_mode != MODE_IDLE && n < max_steps) begin
      send_word(step_word());
      n++;
    end
    repeat (extra_steps) send_word(step_word());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(input logic [FRAME_W-1:0] mx, input logic [FRAME_W-1:0] my);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FRAME_MAX_X;
    cfg_data  <= mx;
    do @(posedge clk); while (!cfg_ready);
    frame_lim_x = mx;
    cfg_index <= CFG_FRAME_MAX_Y;
    cfg_data  <= my;
    do @(posedge clk); while (!cfg_ready);
    frame_lim_y = my;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_shapes();
    rect_word_t w;
    send_idle_pct = 29;
    stall_pct     = 29;
    // full outline, corners written twice, then a step while idle
    draw_rect(FUNC_OUTLINE, 10, 10, 11, 11, 24'hFF00FF, 100, 1);
    // leave a rectangle half drawn; the next start abandons it
    draw_rect(FUNC_OUTLINE, 100, 100, 103, 103, 24'h0000FF, 3, 0);
    draw_rect(FUNC_FILL, -4096, 478, 1, 4095, 24'h00FF00, 100, 0);
    // every edge off frame: nothing drawn
    draw_rect(FUNC_OUTLINE, -4096, -4096, 4095, 4095, 24'hFFFFFF, 100, 1);
    draw_rect(FUNC_FILL, 5, 5, 4, 9, 24'h000000, 100, 1);
    w = step_word();
    w.func = FUNC_UNUSED;
    send_word(w);
    drain();
  endtask

  task automatic test_mid_draw_config();
    send_idle_pct = 29;
    stall_pct     = 29;
    draw_rect(FUNC_OUTLINE, 0, 0, 2, 2, 24'h123456, 3, 0);
    drain();
    // bounds were latched at start: the rest of the outline must not change
    write_frame(12'd0, 12'd0);
    while (pen_mode != MODE_IDLE) send_word(step_word());
    draw_rect(FUNC_FILL, -3, -3, 5, 5, 24'hA5C3E7, 100, 1);
    draw_rect(FUNC_OUTLINE, 0, 0, 0, 0, 24'h5A3C18, 100, 1);
    drain();
    write_frame(12'd4095, 12'd4095);
    draw_rect(FUNC_OUTLINE, 4093, 4094, 4095, 4095, 24'h8001FE, 100, 1);
    draw_rect(FUNC_FILL, 4094, -1, 4095, 1, 24'h7F80FF, 100, 0);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    // hold the output so the pipeline fills and the input stalls
    hold_left = 150;
    draw_rect(FUNC_FILL, 1, 1, 4, 4, 24'h3CC3A5, 100, 0);
    drain();
  endtask

  task automatic random_rect();
    int         lf, tp, rt, bt, pick;
    rect_word_t w;
    logic [1:0] func;
    pick = int'($urandom_range(0, 99));
    if (pick < 6) begin
      w = step_word();
      w.func = pick[0] ? FUNC_UNUSED : FUNC_STEP;
      send_word(w);
    end else begin
      func = pick[0] ? FUNC_FILL : FUNC_OUTLINE;
      lf = near_edge(int'(frame_lim_x));
      tp = near_edge(int'(frame_lim_y));
      rt = fit_coord(lf + int'($urandom_range(0, 6)) - 1);
      bt = fit_coord(tp + int'($urandom_range(0, 6)) - 1);
      if (pick < 16) begin
        case ($urandom_range(0, 3))
          0:       lf = int'($urandom_range(0, 8191)) - 4096;
          1:       tp = int'($urandom_range(0, 8191)) - 4096;
          2:       rt = int'($urandom_range(0, 8191)) - 4096;
          default: bt = int'($urandom_range(0, 8191)) - 4096;
        endcase
      end
      draw_rect(func, lf, tp, rt, bt, 24'($urandom),
                ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 8)) : 80,
                int'($urandom_range(0, 2)));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int blk = 0; blk < 8; blk++) begin
      drain();
      case (blk)
        0:       write_frame(12'd15, 12'd11);
        1:       write_frame(12'd4095, 12'd4095);
        2:       write_frame(12'd7, 12'd30);
        3:       write_frame(12'd639, 12'd479);
        4:       write_frame(12'd3, 12'd2);
        5:       write_frame(12'd4095, 12'd0);
        6:       write_frame(12'd0, 12'd4095);
        default: write_frame(12'd31, 12'd20);
      endcase
      case (blk / 2)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 76; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      target = words_sent + 45;
      while (words_sent < target) random_rect();
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_write_valid, out_pixel_x, out_pixel_y, out_red_out, out_green_out,
             out_blue_out, out_last_write, out_busy_res};
      if (pixel_results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result word with none due: %h", $realtime, got);
      end else begin
        want = pixel_results_due.pop_front();
        results_seen++;
        if (got.write_valid) writes_seen++;
        if (got.write_valid !== want.write_valid || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.last_write !== want.last_write || got.busy !== want.busy) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: wrong result: want wv=%b x=%0d y=%0d rgb=%h%h%h last=%b busy=%b",
                     $realtime, want.write_valid, want.pixel_x, want.pixel_y, want.red,
                     want.green, want.blue, want.last_write, want.busy);
            $display("%0t:               got  wv=%b x=%0d y=%0d rgb=%h%h%h last=%b busy=%b",
                     $realtime, got.write_valid, got.pixel_x, got.pixel_y, got.red,
                     got.green, got.blue, got.last_write, got.busy);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_shapes();
    test_mid_draw_config();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    errors += pixel_results_due.size();
    $display("Sent %0d words over 9 frame sizes and 4 idling mixes; checked %0d results",
             words_sent, results_seen);
    $display("including %0d pixel writes, %0d faults found", writes_seen, errors);
    if (errors == 0) begin
      $display("clipped_rectangle_rasterizer: match");
    end else begin
      $display("clipped_rectangle_rasterizer: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d results outstanding", pixel_results_due.size());
    $display("clipped_rectangle_rasterizer: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hdl/crr_pkg.sv
hdl/crr_clip.sv
hdl/crr_engine.sv
hdl/clipped_rectangle_rasterizer.sv
tb/tb_clipped_rectangle_rasterizer.sv
